>>> rtl/core/bvlp_pkg.sv
`default_nettype none
package bvlp_pkg;

    localparam int OFS_W        = 48;
    localparam int STRIDE_W     = 20;
    localparam int COUNT_W      = 24;
    localparam int BYTES_W      = 13;
    localparam int SIZE_W       = COUNT_W + BYTES_W;
    localparam int NUM_W        = 4;
    localparam int PEND_DEPTH   = 16;
    localparam int PEND_W       = 5;
    localparam int SALIGN_W     = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int MOD_BITS     = 4;
    localparam int MOD_ITER     = OFS_W / MOD_BITS;
    localparam int MOD_CNT_W    = $clog2(MOD_ITER);
    localparam int QUEUE_DEPTH  = 2;
    localparam int MAX_VIEWS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SALIGN = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
        logic [BYTES_W-1:0] align;
        logic               last;
        logic [SIZE_W-1:0]  size;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_VIEW,
        ST_VMOD,
        ST_CSTART,
        ST_CMOD,
        ST_CMUL,
        ST_CADD,
        ST_EMIT,
        ST_LMOD,
        ST_LOUT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/bvlp_front.sv
`default_nettype none
module bvlp_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bvlp_pkg::COUNT_W-1:0]  s_element_count,
    input  wire logic [bvlp_pkg::BYTES_W-1:0]  s_element_bytes,
    input  wire logic [bvlp_pkg::BYTES_W-1:0]  s_view_alignment,
    input  wire logic                          s_last_view,
    output logic                               f_valid,
    input  wire logic                          f_ready,
    output bvlp_pkg::item_t                    f_item
);
    import bvlp_pkg::*;

    logic  stage_valid_reg;
    item_t stage_reg;

    assign s_ready = !stage_valid_reg || f_ready;
    assign f_valid = stage_valid_reg;
    assign f_item  = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_reg.count <= s_element_count;
            stage_reg.bytes <= s_element_bytes;
            stage_reg.align <= s_view_alignment;
            stage_reg.last  <= s_last_view;
            stage_reg.size  <= SIZE_W'(s_element_count) * SIZE_W'(s_element_bytes);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bvlp_queue.sv
`default_nettype none
module bvlp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bvlp_pkg::item_t  in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bvlp_pkg::item_t       out_item
);
    import bvlp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     fill_reg;
    logic               push;
    logic               pop;

    assign in_ready  = fill_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bvlp_mod.sv
`default_nettype none
module bvlp_mod (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bvlp_pkg::OFS_W-1:0]    dividend,
    input  wire logic [bvlp_pkg::BYTES_W-1:0]  divisor,
    output logic                               done,
    output logic [bvlp_pkg::BYTES_W-1:0]       remainder
);
    import bvlp_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [MOD_CNT_W-1:0]   cnt_reg;
    logic [OFS_W-1:0]       dvd_reg;
    logic [BYTES_W-1:0]     dvs_reg;
    logic [BYTES_W-1:0]     rem_reg;
    logic [BYTES_W-1:0]     rem_next;

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_comb begin
        logic [BYTES_W:0] r;
        r = {1'b0, rem_reg};
        for (int k = 0; k < MOD_BITS; k++) begin
            r = {r[BYTES_W-1:0], dvd_reg[OFS_W-1-k]};
            if (r >= {1'b0, dvs_reg}) begin
                r = r - {1'b0, dvs_reg};
            end
        end
        rem_next = r[BYTES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(MOD_ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bvlp_back.sv
`default_nettype none
module bvlp_back #(
    parameter int MAX_VIEWS = bvlp_pkg::MAX_VIEWS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire bvlp_pkg::item_t                  q_item,
    input  wire logic                             cfg_we,
    input  wire logic [bvlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bvlp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bvlp_pkg::NUM_W-1:0]            m_view_number,
    output logic [bvlp_pkg::OFS_W-1:0]            m_byte_offset,
    output logic [bvlp_pkg::STRIDE_W-1:0]         m_byte_stride,
    output logic [bvlp_pkg::OFS_W-1:0]            m_total_size,
    output logic                                  m_final_result
);
    import bvlp_pkg::*;

    localparam int GROUP_CAP = (MAX_VIEWS < PEND_DEPTH) ? MAX_VIEWS : PEND_DEPTH;
    localparam int PROD_W    = STRIDE_W + COUNT_W;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic                   mode_reg;
    logic [SALIGN_W-1:0]    salign_reg;
    logic [OFS_W-1:0]       pend_mem [PEND_DEPTH];
    logic [PEND_W-1:0]      pend_reg, pend_next;
    logic [COUNT_W-1:0]     gec_reg, gec_next;
    logic [STRIDE_W-1:0]    gs_reg, gs_next;
    logic [OFS_W-1:0]       rs_reg, rs_next;
    logic [OFS_W-1:0]       prev_reg, prev_next;
    logic [NUM_W-1:0]       vc_reg, vc_next;
    logic [OFS_W-1:0]       off_reg, off_next;
    logic [STRIDE_W-1:0]    stride_reg, stride_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [NUM_W-1:0]       idx_reg, idx_next;
    logic                   cfin_reg, cfin_next;
    logic                   cview_reg, cview_next;

    logic                   m_valid_reg, m_valid_next;
    logic [NUM_W-1:0]       m_num_reg, m_num_next;
    logic [OFS_W-1:0]       m_off_reg, m_off_next;
    logic [STRIDE_W-1:0]    m_stride_reg, m_stride_next;
    logic [OFS_W-1:0]       m_total_reg, m_total_next;
    logic                   m_fin_reg, m_fin_next;

    logic                   pend_we;
    logic [OFS_W-1:0]       pend_wdata;
    logic                   mod_start;
    logic [OFS_W-1:0]       mod_dvd;
    logic [BYTES_W-1:0]     mod_dvs;
    logic                   mod_done;
    logic [BYTES_W-1:0]     mod_rem;

    logic [BYTES_W-1:0]     align_eff;
    logic [BYTES_W-1:0]     sa_eff;
    logic [BYTES_W-1:0]     gap_a;
    logic [BYTES_W-1:0]     gap_s;
    logic [BYTES_W-1:0]     pad_lin;
    logic [BYTES_W-1:0]     pad_view;
    logic [STRIDE_W-1:0]    gs_use;
    logic [PEND_W-1:0]      pend_inc;
    logic                   out_free;
    logic                   emit_last;

    bvlp_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (mod_dvs),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign m_valid        = m_valid_reg;
    assign m_view_number  = m_num_reg;
    assign m_byte_offset  = m_off_reg;
    assign m_byte_stride  = m_stride_reg;
    assign m_total_size   = m_total_reg;
    assign m_final_result = m_fin_reg;

    assign align_eff = (item_reg.align == '0) ? BYTES_W'(1) : item_reg.align;
    assign sa_eff    = (salign_reg == '0) ? BYTES_W'(1) : BYTES_W'(salign_reg);
    assign gap_a     = align_eff - mod_rem;
    assign gap_s     = sa_eff - mod_rem;
    assign pad_lin   = (mod_rem != '0 && item_reg.size > SIZE_W'(gap_a)) ? gap_a : '0;
    assign pad_view  = (mod_rem != '0 && item_reg.bytes > gap_a) ? gap_a : '0;
    assign gs_use    = (pend_reg == '0) ? '0 : gs_reg;
    assign pend_inc  = pend_reg + 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_last = (PEND_W'(idx_reg) + 1'b1) == pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            salign_reg  <= SALIGN_W'(16);
            pend_reg    <= '0;
            gec_reg     <= '0;
            gs_reg      <= '0;
            rs_reg      <= '0;
            prev_reg    <= '0;
            vc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            gec_reg     <= gec_next;
            gs_reg      <= gs_next;
            rs_reg      <= rs_next;
            prev_reg    <= prev_next;
            vc_reg      <= vc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == CFG_MODE) begin
                mode_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == CFG_SALIGN) begin
                salign_reg <= cfg_data[SALIGN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        off_reg      <= off_next;
        stride_reg   <= stride_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        cfin_reg     <= cfin_next;
        cview_reg    <= cview_next;
        m_num_reg    <= m_num_next;
        m_off_reg    <= m_off_next;
        m_stride_reg <= m_stride_next;
        m_total_reg  <= m_total_next;
        m_fin_reg    <= m_fin_next;
        if (pend_we) begin
            pend_mem[pend_reg[NUM_W-1:0]] <= pend_wdata;
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        pend_next     = pend_reg;
        gec_next      = gec_reg;
        gs_next       = gs_reg;
        rs_next       = rs_reg;
        prev_next     = prev_reg;
        vc_next       = vc_reg;
        off_next      = off_reg;
        stride_next   = stride_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        cfin_next     = cfin_reg;
        cview_next    = cview_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_num_next    = m_num_reg;
        m_off_next    = m_off_reg;
        m_stride_next = m_stride_reg;
        m_total_next  = m_total_reg;
        m_fin_next    = m_fin_reg;
        pend_we       = 1'b0;
        pend_wdata    = off_reg + OFS_W'(pad_view);
        mod_start     = 1'b0;
        mod_dvd       = prev_reg;
        mod_dvs       = align_eff;
        q_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next  = q_item;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!mode_reg) begin
                    mod_start  = 1'b1;
                    state_next = ST_LMOD;
                end else if (pend_reg != '0 && item_reg.count != gec_reg) begin
                    cfin_next  = 1'b0;
                    cview_next = 1'b1;
                    state_next = ST_CSTART;
                end else begin
                    state_next = ST_VIEW;
                end
            end
            ST_VIEW: begin
                if (pend_reg == '0) begin
                    gec_next = item_reg.count;
                    gs_next  = '0;
                end
                off_next   = rs_reg + OFS_W'(gs_use);
                mod_dvd    = rs_reg + OFS_W'(gs_use);
                mod_start  = 1'b1;
                state_next = ST_VMOD;
            end
            ST_VMOD: begin
                if (mod_done) begin
                    pend_we   = 1'b1;
                    pend_next = pend_inc;
                    gs_next   = gs_reg + STRIDE_W'(item_reg.bytes) + STRIDE_W'(pad_view);
                    vc_next   = vc_reg + 1'b1;
                    if (item_reg.last || pend_inc >= PEND_W'(GROUP_CAP)) begin
                        cfin_next  = item_reg.last;
                        cview_next = 1'b0;
                        state_next = ST_CSTART;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CSTART: begin
                mod_dvd    = OFS_W'(gs_reg);
                mod_dvs    = sa_eff;
                mod_start  = 1'b1;
                state_next = ST_CMOD;
            end
            ST_CMOD: begin
                if (mod_done) begin
                    stride_next = gs_reg + ((mod_rem != '0) ? STRIDE_W'(gap_s) : '0);
                    state_next  = ST_CMUL;
                end
            end
            ST_CMUL: begin
                prod_next  = PROD_W'(stride_reg) * PROD_W'(gec_reg);
                state_next = ST_CADD;
            end
            ST_CADD: begin
                rs_next    = rs_reg + OFS_W'(prod_reg);
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_num_next    = vc_reg - pend_reg[NUM_W-1:0] + idx_reg;
                    m_off_next    = pend_mem[idx_reg];
                    m_stride_next = stride_reg;
                    m_total_next  = rs_reg;
                    m_fin_next    = cfin_reg && emit_last;
                    idx_next      = idx_reg + 1'b1;
                    if (emit_last) begin
                        pend_next = '0;
                        gs_next   = '0;
                        if (cfin_reg) begin
                            gec_next   = '0;
                            rs_next    = '0;
                            prev_next  = '0;
                            vc_next    = '0;
                            state_next = ST_IDLE;
                        end else if (cview_reg) begin
                            state_next = ST_VIEW;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_LMOD: begin
                if (mod_done) begin
                    off_next   = prev_reg + OFS_W'(pad_lin);
                    rs_next    = rs_reg + OFS_W'(item_reg.size) + OFS_W'(pad_lin);
                    prev_next  = prev_reg + OFS_W'(pad_lin) + OFS_W'(item_reg.size);
                    state_next = ST_LOUT;
                end
            end
            ST_LOUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_num_next    = vc_reg;
                    m_off_next    = off_reg;
                    m_stride_next = STRIDE_W'(item_reg.bytes);
                    m_total_next  = rs_reg;
                    m_fin_next    = item_reg.last;
                    vc_next       = vc_reg + 1'b1;
                    if (item_reg.last) begin
                        pend_next = '0;
                        gec_next  = '0;
                        gs_next   = '0;
                        rs_next   = '0;
                        prev_next = '0;
                        vc_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // drop the layout in progress on a mode write
        if (cfg_we && cfg_index == CFG_MODE) begin
            pend_next = '0;
            gec_next  = '0;
            gs_next   = '0;
            rs_next   = '0;
            prev_next = '0;
            vc_next   = '0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/buffer_view_layout_planner_unit.sv
`default_nettype none
// In linear mode each accepted beat gives one result; in interleaved mode the group
// results follow the closing view, one result beat per cycle unless m_ready stalls.
// The back end takes a new view only once the shared remainder unit (4 bits per
// cycle over 48 bits) is done with the last; a group close adds a stride remainder
// pass before its results. Reset: synchronous active-low aresetn resets control,
// config and layout state; the pending offset store is not cleared.
module buffer_view_layout_planner_unit #(
    parameter int MAX_VIEWS = bvlp_pkg::MAX_VIEWS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bvlp_pkg::COUNT_W-1:0]     s_element_count,
    input  wire logic [bvlp_pkg::BYTES_W-1:0]     s_element_bytes,
    input  wire logic [bvlp_pkg::BYTES_W-1:0]     s_view_alignment,
    input  wire logic                             s_last_view,
    input  wire logic                             cfg_we,
    input  wire logic [bvlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bvlp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bvlp_pkg::NUM_W-1:0]            m_view_number,
    output logic [bvlp_pkg::OFS_W-1:0]            m_byte_offset,
    output logic [bvlp_pkg::STRIDE_W-1:0]         m_byte_stride,
    output logic [bvlp_pkg::OFS_W-1:0]            m_total_size,
    output logic                                  m_final_result
);
    import bvlp_pkg::*;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    bvlp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_count  (s_element_count),
        .s_element_bytes  (s_element_bytes),
        .s_view_alignment (s_view_alignment),
        .s_last_view      (s_last_view),
        .f_valid          (f_valid),
        .f_ready          (f_ready),
        .f_item           (f_item)
    );

    bvlp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    bvlp_back #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_view_number  (m_view_number),
        .m_byte_offset  (m_byte_offset),
        .m_byte_stride  (m_byte_stride),
        .m_total_size   (m_total_size),
        .m_final_result (m_final_result)
    );

endmodule
`default_nettype wire
